// ----- src/itrd_pkg.sv -----
// Package for integer_to_radix_digits: sizes, codes, command and result types.
// Used by the interfaces, the front, the queue, the back end and the top level.
package itrd_pkg;

    localparam int MAX_DIGITS = 64;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = $clog2(MAX_DIGITS);

    localparam int VALUE_W = 64;
    localparam int MAG_W   = 63;
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 6;

    // bits of dividend consumed per divider cycle
    localparam int STEP_BITS  = 8;
    localparam int DIV_CYCLES = (MAG_W + 1) / STEP_BITS;
    localparam int DCYC_W     = $clog2(DIV_CYCLES);

    localparam logic [RADIX_W-1:0] RADIX_LOW  = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_HIGH = 6'd36;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPPER = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] ASCII_NUL   = 7'h00;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic [MAG_W-1:0]   mag;
        logic [RADIX_W-1:0] radix;
        logic               neg;
        logic               err;
    } t_cmd;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              status;
        logic              last;
    } t_res;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] r;
        if (d < DEC_DIGITS) begin
            r = ASCII_ZERO + CHAR_W'(d);
        end else begin
            r = ASCII_UPPER + CHAR_W'(d - DEC_DIGITS);
        end
        return r;
    endfunction

endpackage

// ----- src/itrd_in_if.sv -----
// Input channel of integer_to_radix_digits: valid/ready plus value and radix.
// Depends on itrd_pkg for field widths.
interface itrd_in_if;
    import itrd_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

// ----- src/itrd_out_if.sv -----
// Output channel of integer_to_radix_digits: valid/ready plus one character item.
// Depends on itrd_pkg for field widths.
interface itrd_out_if;
    import itrd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              status;
    logic              last;

    modport source (output valid, output character, output status, output last,
                    input ready);
    modport sink   (input valid, input character, input status, input last,
                    output ready);
endinterface

// ----- src/itrd_front.sv -----
// Front end: accepts input items, checks the radix, forms the saturated magnitude.
// Depends on itrd_pkg and itrd_in_if.
module itrd_front (
    itrd_in_if.sink        i_in,
    output itrd_pkg::t_cmd o_cmd,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready
);
    import itrd_pkg::*;

    logic [VALUE_W-1:0] w_abs;

    always_comb begin
        w_abs = i_in.value[VALUE_W-1] ? (~i_in.value + VALUE_W'(1)) : i_in.value;
        o_cmd.err   = (i_in.radix < RADIX_LOW) || (i_in.radix > RADIX_HIGH);
        o_cmd.neg   = i_in.value[VALUE_W-1];
        o_cmd.radix = i_in.radix;
        // only the most negative value leaves bit 63 set; clamp it
        o_cmd.mag   = w_abs[VALUE_W-1] ? {MAG_W{1'b1}} : w_abs[MAG_W-1:0];
    end

    assign o_cmd_valid = i_in.valid;
    assign i_in.ready  = i_cmd_ready;

endmodule

// ----- src/itrd_queue.sv -----
// Two-entry command queue between front and back end.
// Depends on itrd_pkg.
module itrd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  itrd_pkg::t_cmd i_push,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    output itrd_pkg::t_cmd o_pop,
    output logic           o_pop_valid,
    input  logic           i_pop_ready
);
    import itrd_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop        = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// ----- src/itrd_back.sv -----
// Back end: radix-serial divider filling the digit store, then the character emitter.
// Depends on itrd_pkg and itrd_out_if.
module itrd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  itrd_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    itrd_out_if.source     o_out
);
    import itrd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SIGN = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [MAG_W:0]     r_shr, n_shr;      // dividend in, quotient out
    logic [DIGIT_W-1:0] r_rem, n_rem;
    logic [DCYC_W-1:0]  r_cyc, n_cyc;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [RADIX_W-1:0] r_radix, n_radix;
    logic               r_neg, n_neg;
    logic               r_ov, n_ov;
    t_res               r_out, n_out;

    logic [DIGIT_W-1:0] r_store [MAX_DIGITS];
    logic [DIGIT_W-1:0] r_rdata;
    logic [CNT_W-1:0]   w_rd_ptr;

    logic [DIGIT_W-1:0]   w_rem;
    logic [STEP_BITS-1:0] w_qb;
    logic                 w_free;
    logic                 w_last_cyc;
    logic                 w_wr;

    // eight restoring steps on the narrow remainder per cycle
    always_comb begin
        logic [DIGIT_W:0] t;
        w_rem = r_rem;
        w_qb  = '0;
        for (int k = 0; k < STEP_BITS; k++) begin
            t = {w_rem, r_shr[MAG_W - k]};
            if (t >= {1'b0, r_radix}) begin
                w_rem = DIGIT_W'(t - {1'b0, r_radix});
                w_qb[STEP_BITS-1-k] = 1'b1;
            end else begin
                w_rem = t[DIGIT_W-1:0];
            end
        end
    end

    assign w_free      = !r_ov || o_out.ready;
    assign w_last_cyc  = (r_cyc == DCYC_W'(DIV_CYCLES - 1));
    assign w_wr        = (r_state == S_DIV) && w_last_cyc;
    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_rd_ptr    = r_idx - CNT_W'(1);

    always_comb begin
        n_state = r_state;
        n_shr   = r_shr;
        n_rem   = r_rem;
        n_cyc   = r_cyc;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_radix = r_radix;
        n_neg   = r_neg;
        n_ov    = r_ov && !o_out.ready;
        n_out   = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_radix = i_cmd.radix;
                    n_neg   = i_cmd.neg;
                    n_shr   = {1'b0, i_cmd.mag};
                    n_rem   = '0;
                    n_cyc   = '0;
                    n_cnt   = '0;
                    n_state = i_cmd.err ? S_ERR : S_DIV;
                end
            end
            S_DIV: begin
                n_shr = {r_shr[MAG_W-STEP_BITS:0], w_qb};
                n_rem = w_rem;
                n_cyc = r_cyc + DCYC_W'(1);
                if (w_last_cyc) begin
                    n_cnt = r_cnt + CNT_W'(1);
                    n_rem = '0;
                    // do-while: a zero value still yields one digit
                    if ((n_shr == '0) || (n_cnt == CNT_W'(MAX_DIGITS))) begin
                        n_idx   = n_cnt;
                        n_state = r_neg ? S_SIGN : S_RD;
                    end
                end
            end
            S_SIGN: begin
                if (w_free) begin
                    n_ov    = 1'b1;
                    n_out   = '{character: ASCII_MINUS, status: STATUS_OK, last: 1'b0};
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_free) begin
                    n_ov    = 1'b1;
                    n_out   = '{character: digit_char(r_rdata), status: STATUS_OK,
                                last: (r_idx == CNT_W'(1))};
                    n_idx   = r_idx - CNT_W'(1);
                    n_state = (r_idx == CNT_W'(1)) ? S_IDLE : S_RD;
                end
            end
            S_ERR: begin
                if (w_free) begin
                    n_ov    = 1'b1;
                    n_out   = '{character: ASCII_NUL, status: STATUS_BAD, last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_store[r_cnt[IDX_W-1:0]] <= w_rem;
        end
        if (r_state == S_RD) begin
            r_rdata <= r_store[w_rd_ptr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_cyc   <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_neg   <= 1'b0;
            r_radix <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_cyc   <= n_cyc;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_neg   <= n_neg;
            r_radix <= n_radix;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shr <= n_shr;
        r_rem <= n_rem;
        r_out <= n_out;
    end

    assign o_out.valid     = r_ov;
    assign o_out.character = r_out.character;
    assign o_out.status    = r_out.status;
    assign o_out.last      = r_out.last;

    a_idx_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT || r_state == S_RD) |-> (r_idx != '0))
        else $error("emit index underflow");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond store depth");

    a_err_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.status) |-> (r_out.character == ASCII_NUL && r_out.last))
        else $error("error item malformed");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_radix))
        else $error("remainder not below radix");

endmodule

// ----- src/integer_to_radix_digits.sv -----
// Top level of integer_to_radix_digits: front end, command queue, back end.
// Depends on itrd_pkg, itrd_in_if, itrd_out_if, itrd_front, itrd_queue, itrd_back.
//
// Usage:
//   i_in  carries one item per conversion: a signed 64-bit value and a 6-bit radix.
//   o_out carries one item per character, most significant first: '-' for a
//         negative value, then '0'-'9'/'A'-'Z'; last marks the final character.
//   A radix outside 2..36 gives a single item: character 0, status 1, last 1.
//   Zero converts to "0". The most negative value clamps to -(2^63-1).
// Timing:
//   The front checks the radix and forms the magnitude combinationally and
//   pushes a command into a two-entry queue, so up to two items are taken
//   while the back end is busy. The back end divides 8 bits per cycle
//   for each digit; each character is then read from the digit store and
//   loaded into the output register. The back end takes a new item only
//   when it is idle, after the last character of the previous item or its
//   error item has been loaded.
// Reset (synchronous, active low) empties the queue and output register; the
// digit store is not cleared. A stalled receiver holds the output item and
// the back end waits; the queue keeps accepting until full.
module integer_to_radix_digits (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itrd_in_if.sink    i_in,
    itrd_out_if.source o_out
);
    import itrd_pkg::*;

    t_cmd w_fr_cmd, w_q_cmd;
    logic w_fr_valid, w_fr_ready;
    logic w_q_valid, w_q_ready;

    // classify and saturate the incoming item
    itrd_front u_front (
        .i_in        (i_in),
        .o_cmd       (w_fr_cmd),
        .o_cmd_valid (w_fr_valid),
        .i_cmd_ready (w_fr_ready)
    );

    // decouples intake from the long conversion
    itrd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_fr_cmd),
        .i_push_valid (w_fr_valid),
        .o_push_ready (w_fr_ready),
        .o_pop        (w_q_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready)
    );

    // division into the digit store, then character output
    itrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_q_cmd),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .o_out       (o_out)
    );

endmodule
